/* rtl/u8v_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 validator package
// Shared item type and queue constants for the UTF-8 record validator.
// ----------------------------------------------------------------------------
package u8v_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic       present;
    logic       last;
    logic [7:0] data;
    logic       is_cont;
    logic [1:0] seq_len;
    logic       lead_err;
  } u8v_item_t;

  typedef struct packed {
    logic full;
    logic head_valid;
  } u8v_qstat_t;

endpackage

/* rtl/u8v_front.sv */
// ----------------------------------------------------------------------------
// UTF-8 validator front end
// Accepts words and classifies each byte as a lead or continuation byte.
// ----------------------------------------------------------------------------
module u8v_front
  import u8v_pkg::*;
(
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       byte_present,
  input  logic       record_end,
  input  u8v_qstat_t qstat,
  output logic       push,
  output u8v_item_t  item
);

  logic [1:0] seq_len;
  logic       lead_err;

  always_comb begin
    seq_len  = 2'd0;
    lead_err = 1'b0;
    priority if (data_byte[7] == 1'b0) begin
      seq_len = 2'd0;
    end else if ((data_byte & 8'he0) == 8'hc0) begin
      seq_len  = 2'd1;
      lead_err = ((data_byte & 8'h1e) == 8'h00);
    end else if ((data_byte & 8'hf0) == 8'he0) begin
      seq_len = 2'd2;
    end else if ((data_byte & 8'hf8) == 8'hf0) begin
      seq_len  = 2'd3;
      lead_err = (data_byte > 8'hf4);
    end else begin
      lead_err = 1'b1;
    end
  end

  assign in_stall      = qstat.full;
  assign push          = in_valid && !qstat.full;
  assign item.present  = byte_present;
  assign item.last     = record_end;
  assign item.data     = data_byte;
  assign item.is_cont  = ((data_byte & 8'hc0) == 8'h80);
  assign item.seq_len  = seq_len;
  assign item.lead_err = lead_err;

endmodule

/* rtl/u8v_queue.sv */
// ----------------------------------------------------------------------------
// UTF-8 validator queue
// Short FIFO of classified words between the front and back ends.
// ----------------------------------------------------------------------------
module u8v_queue
  import u8v_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  u8v_item_t  push_item,
  input  logic       pop,
  output u8v_item_t  head,
  output u8v_qstat_t qstat
);

  u8v_item_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head             = mem[rd_ptr];
  assign qstat.full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign qstat.head_valid = (count != '0);

endmodule

/* rtl/u8v_back.sv */
// ----------------------------------------------------------------------------
// UTF-8 validator back end
// Tracks the open multi-byte sequence and delivers one result per record.
// ----------------------------------------------------------------------------
module u8v_back
  import u8v_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  u8v_item_t head,
  input  logic      head_valid,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output logic      record_valid
);

  logic [1:0] bytes_left;
  logic [7:0] lead_byte;
  logic       at_second_byte;
  logic       error_seen;

  logic [1:0] bytes_left_next;
  logic [7:0] lead_byte_next;
  logic       at_second_byte_next;
  logic       error_seen_next;

  assign pop = head_valid && !(out_valid && out_stall);

  always_comb begin
    bytes_left_next     = bytes_left;
    lead_byte_next      = lead_byte;
    at_second_byte_next = at_second_byte;
    error_seen_next     = error_seen;
    if (head.present) begin
      if (bytes_left != 2'd0) begin
        if (!head.is_cont) begin
          error_seen_next = 1'b1;
        end
        if (at_second_byte) begin
          if ((lead_byte & 8'hf0) == 8'he0) begin
            if ((lead_byte & 8'h0f) == 8'h00 && (head.data & 8'h20) == 8'h00) begin
              error_seen_next = 1'b1;
            end
            if (lead_byte == 8'hed && (head.data & 8'h20) != 8'h00) begin
              error_seen_next = 1'b1;
            end
          end else if ((lead_byte & 8'hf8) == 8'hf0) begin
            if ((lead_byte & 8'h07) == 8'h00 && (head.data & 8'h30) == 8'h00) begin
              error_seen_next = 1'b1;
            end
            if (lead_byte == 8'hf4 && head.data > 8'h8f) begin
              error_seen_next = 1'b1;
            end
          end
        end
        at_second_byte_next = 1'b0;
        bytes_left_next     = bytes_left - 2'd1;
      end else begin
        bytes_left_next     = head.seq_len;
        at_second_byte_next = (head.seq_len != 2'd0);
        if (head.seq_len != 2'd0) begin
          lead_byte_next = head.data;
        end
        if (head.lead_err) begin
          error_seen_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left     <= 2'd0;
      lead_byte      <= 8'h00;
      at_second_byte <= 1'b0;
      error_seen     <= 1'b0;
      out_valid      <= 1'b0;
      record_valid   <= 1'b0;
    end else begin
      if (pop) begin
        if (head.last) begin
          bytes_left     <= 2'd0;
          lead_byte      <= 8'h00;
          at_second_byte <= 1'b0;
          error_seen     <= 1'b0;
          out_valid      <= 1'b1;
          record_valid   <= !(error_seen_next || bytes_left_next != 2'd0);
        end else begin
          bytes_left     <= bytes_left_next;
          lead_byte      <= lead_byte_next;
          at_second_byte <= at_second_byte_next;
          error_seen     <= error_seen_next;
          if (!out_stall) begin
            out_valid <= 1'b0;
          end
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/utf8_stream_validator_core.sv */
// Path: each word is written into the queue memory, popped by the back end, and a record's result is registered.
// Throughput: one word per cycle while a waiting result is not held by out_stall.
// A two-entry queue between front and back end lets either side stall on its own.
// Reset: synchronous and active high; it empties the queue and clears the sequence state.
// ----------------------------------------------------------------------------
// UTF-8 stream validator
// Checks records of a byte stream for well-formed UTF-8, one result per record.
// ----------------------------------------------------------------------------
module utf8_stream_validator_core
  import u8v_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       byte_present,
  input  logic       record_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       record_valid
);

  u8v_qstat_t qstat;
  u8v_item_t  push_item;
  u8v_item_t  head;
  logic       push;
  logic       pop;

  u8v_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .byte_present (byte_present),
    .record_end   (record_end),
    .qstat        (qstat),
    .push         (push),
    .item         (push_item)
  );

  u8v_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  u8v_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (qstat.head_valid),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .record_valid (record_valid)
  );

  a_pop_needs_word: assert property (@(posedge clk) disable iff (rst)
    pop |-> qstat.head_valid)
    else $error("Word popped from an empty queue.");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !push)
    else $error("Word pushed into a full queue.");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (pop && head.last) |=> out_valid)
    else $error("Record end popped without a result.");

  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("Input stalled right after reset.");

endmodule
